@@ rtl/lpcp_pkg.sv @@
`timescale 1ns / 1ps
package lpcp_pkg;

   localparam int COORD_W = 32;
   localparam int CSR_W = 64;
   localparam int CSR_INDEX_W = 3;
   localparam int NUM_COEF = 6;

   localparam logic [CSR_INDEX_W-1:0] REG_COEF_U_XY = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_COEF_U_ZT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_COEF_V_XY = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_COEF_V_ZT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_COEF_W_XY = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_COEF_W_ZT = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_SIZE = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_KEEP_UNPROJECTED = 3'd7;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } point_type;

   typedef struct packed {
      logic      valid;
      point_type point;
      logic      w_pos;
      logic      ok_u;
      logic      ok_v;
   } side_type;

endpackage

@@ rtl/lpcp_if.sv @@
`timescale 1ns / 1ps
interface lpcp_req_if;
   logic valid;
   logic ready;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   logic signed [31:0] point_z;
   modport source(output valid, output point_x, output point_y, output point_z, input ready);
   modport sink(input valid, input point_x, input point_y, input point_z, output ready);
endinterface

interface lpcp_rsp_if #(parameter int PIXEL_BITS = 12);
   logic valid;
   logic ready;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   logic signed [31:0] out_z;
   logic [PIXEL_BITS-1:0] pixel_col;
   logic [PIXEL_BITS-1:0] pixel_row;
   logic hit;
   modport source(output valid, output out_x, output out_y, output out_z,
                  output pixel_col, output pixel_row, output hit, input ready);
   modport sink(input valid, input out_x, input out_y, input out_z,
                input pixel_col, input pixel_row, input hit, output ready);
endinterface

@@ rtl/lpcp_dot.sv @@
`timescale 1ns / 1ps
module lpcp_dot import lpcp_pkg::*; #(
   parameter int FRAC_BITS = 16,
   parameter int SUM_W = 50
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic [CSR_W-1:0]        coef_xy,
   input  logic [CSR_W-1:0]        coef_zt,
   input  point_type               point,
   output logic signed [SUM_W-1:0] sum
);

   logic signed [2*COORD_W-1:0] prod_x_ff, prod_y_ff, prod_z_ff;
   logic signed [COORD_W-1:0]   ofs_ff;
   logic signed [SUM_W-1:0]     sum_ff, sum_in;

   // Arithmetic right shift floors each product before the exact sum.
   assign sum_in = SUM_W'(prod_x_ff >>> FRAC_BITS) + SUM_W'(prod_y_ff >>> FRAC_BITS)
                 + SUM_W'(prod_z_ff >>> FRAC_BITS) + SUM_W'(ofs_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         prod_x_ff <= $signed(coef_xy[COORD_W-1:0]) * point.x;
         prod_y_ff <= $signed(coef_xy[2*COORD_W-1:COORD_W]) * point.y;
         prod_z_ff <= $signed(coef_zt[COORD_W-1:0]) * point.z;
         ofs_ff    <= $signed(coef_zt[2*COORD_W-1:COORD_W]);
         sum_ff    <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

@@ rtl/lpcp_div.sv @@
`timescale 1ns / 1ps
module lpcp_div #(
   parameter int DW = 64,
   parameter int QW = 12
) (
   input  logic          clock,
   input  logic          en,
   input  logic [DW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [QW-1:0] quo
);

   logic [DW-1:0] rem_ff [QW];
   logic [DW-1:0] den_ff [QW];
   logic [QW-1:0] quo_ff [QW];

   // Restoring division, one quotient bit per stage, most significant first.
   for (genvar i = 0; i < QW; i++) begin : g_stage
      logic [DW-1:0] rem_src, den_src, dsh, rem_in;
      logic [QW-1:0] quo_src, quo_in;
      logic          ge;
      if (i == 0) begin : g_first
         assign rem_src = num;
         assign den_src = den;
         assign quo_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[i-1];
         assign den_src = den_ff[i-1];
         assign quo_src = quo_ff[i-1];
      end
      assign dsh    = den_src << (QW - 1 - i);
      assign ge     = (rem_src >= dsh);
      assign rem_in = ge ? (rem_src - dsh) : rem_src;
      assign quo_in = quo_src | (ge ? (QW'(1) << (QW - 1 - i)) : QW'(0));
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= rem_in;
            den_ff[i] <= den_src;
            quo_ff[i] <= quo_in;
         end
      end
   end

   assign quo = quo_ff[QW-1];

endmodule

@@ rtl/lidar_point_camera_projection.sv @@
`timescale 1ns / 1ps
// Throughput: one word per cycle; the multiply, sum, setup and one stage per pixel bit
// of the division pipeline all advance together whenever the output register is free.
// A stalled output holds the whole pipeline. Reset is synchronous and active high;
// it clears all valid bits and all configuration registers to zero.
module lidar_point_camera_projection import lpcp_pkg::*; #(
   parameter int FRAC_BITS = 16,
   parameter int PIXEL_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   lpcp_req_if.sink               req_chan,
   lpcp_rsp_if.source             rsp_chan,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]       csr_wdata
);

   localparam int SUM_W = 2 * COORD_W - FRAC_BITS + 2;
   localparam int DW = SUM_W + PIXEL_BITS + 2;

   logic [CSR_W-1:0]        coef_ff [NUM_COEF];
   logic [2*PIXEL_BITS-1:0] image_size_ff;
   logic                    keep_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COEF; i++) coef_ff[i] <= '0;
         image_size_ff <= '0;
         keep_ff       <= 1'b0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_COEF_U_XY: coef_ff[0] <= csr_wdata;
            REG_COEF_U_ZT: coef_ff[1] <= csr_wdata;
            REG_COEF_V_XY: coef_ff[2] <= csr_wdata;
            REG_COEF_V_ZT: coef_ff[3] <= csr_wdata;
            REG_COEF_W_XY: coef_ff[4] <= csr_wdata;
            REG_COEF_W_ZT: coef_ff[5] <= csr_wdata;
            REG_IMAGE_SIZE: image_size_ff <= csr_wdata[2*PIXEL_BITS-1:0];
            REG_KEEP_UNPROJECTED: keep_ff <= csr_wdata[0];
         endcase
      end
   end

   logic en;
   logic rsp_valid_ff;
   assign en = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   point_type req_point;
   assign req_point = '{x: req_chan.point_x, y: req_chan.point_y, z: req_chan.point_z};

   logic signed [SUM_W-1:0] un_s, vn_s, w_s;

   lpcp_dot #(.FRAC_BITS(FRAC_BITS), .SUM_W(SUM_W)) u_dot_u (
      .clock(clock), .en(en), .coef_xy(coef_ff[0]), .coef_zt(coef_ff[1]),
      .point(req_point), .sum(un_s));
   lpcp_dot #(.FRAC_BITS(FRAC_BITS), .SUM_W(SUM_W)) u_dot_v (
      .clock(clock), .en(en), .coef_xy(coef_ff[2]), .coef_zt(coef_ff[3]),
      .point(req_point), .sum(vn_s));
   lpcp_dot #(.FRAC_BITS(FRAC_BITS), .SUM_W(SUM_W)) u_dot_w (
      .clock(clock), .en(en), .coef_xy(coef_ff[4]), .coef_zt(coef_ff[5]),
      .point(req_point), .sum(w_s));

   side_type side1_ff, side2_ff, side3_ff;
   side_type side1_in, side3_in;
   assign side1_in = '{valid: req_chan.valid, point: req_point,
                       w_pos: 1'b0, ok_u: 1'b0, ok_v: 1'b0};

   // Rounding half away from zero: col = floor((2|u| + w) / 2w) with the sign of u.
   // A negative u only hits when it rounds to zero, that is 2|u| < w.
   logic [SUM_W-1:0] un_abs, vn_abs;
   logic [DW-1:0]    w_ext, den_in, limit, twice_u, twice_v, num_u_in, num_v_in;
   logic             w_pos, ok_u_in, ok_v_in;

   assign w_pos    = !w_s[SUM_W-1] && (w_s != '0);
   assign un_abs   = un_s[SUM_W-1] ? SUM_W'(-un_s) : un_s;
   assign vn_abs   = vn_s[SUM_W-1] ? SUM_W'(-vn_s) : vn_s;
   assign w_ext    = DW'(unsigned'(w_s));
   assign den_in   = w_ext << 1;
   assign limit    = den_in << PIXEL_BITS;
   assign twice_u  = DW'(un_abs) << 1;
   assign twice_v  = DW'(vn_abs) << 1;
   assign num_u_in = un_s[SUM_W-1] ? DW'(0) : (twice_u + w_ext);
   assign num_v_in = vn_s[SUM_W-1] ? DW'(0) : (twice_v + w_ext);
   assign ok_u_in  = un_s[SUM_W-1] ? (twice_u < w_ext) : (num_u_in < limit);
   assign ok_v_in  = vn_s[SUM_W-1] ? (twice_v < w_ext) : (num_v_in < limit);

   always_comb begin
      side3_in       = side2_ff;
      side3_in.w_pos = w_pos;
      side3_in.ok_u  = ok_u_in;
      side3_in.ok_v  = ok_v_in;
   end

   logic [DW-1:0] num_u_ff, num_v_ff, den_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         num_u_ff <= num_u_in;
         num_v_ff <= num_v_in;
         den_ff   <= den_in;
      end
   end

   logic [PIXEL_BITS-1:0] quo_u, quo_v;

   lpcp_div #(.DW(DW), .QW(PIXEL_BITS)) u_div_u (
      .clock(clock), .en(en), .num(num_u_ff), .den(den_ff), .quo(quo_u));
   lpcp_div #(.DW(DW), .QW(PIXEL_BITS)) u_div_v (
      .clock(clock), .en(en), .num(num_v_ff), .den(den_ff), .quo(quo_v));

   side_type side_div_ff [PIXEL_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         side1_ff <= '0;
         side2_ff <= '0;
         side3_ff <= '0;
         for (int i = 0; i < PIXEL_BITS; i++) side_div_ff[i] <= '0;
      end else if (en) begin
         side1_ff       <= side1_in;
         side2_ff       <= side1_ff;
         side3_ff       <= side3_in;
         side_div_ff[0] <= side3_ff;
         for (int i = 1; i < PIXEL_BITS; i++) side_div_ff[i] <= side_div_ff[i-1];
      end
   end

   side_type              last;
   logic                  hit_in;
   logic                  rsp_valid_in;
   point_type             out_point_ff;
   logic [PIXEL_BITS-1:0] col_ff, row_ff;
   logic                  hit_ff;

   assign last   = side_div_ff[PIXEL_BITS-1];
   assign hit_in = last.w_pos && last.ok_u && last.ok_v
                && (quo_u < image_size_ff[PIXEL_BITS-1:0])
                && (quo_v < image_size_ff[2*PIXEL_BITS-1:PIXEL_BITS]);
   assign rsp_valid_in = last.valid && (hit_in || keep_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_point_ff <= last.point;
         col_ff       <= hit_in ? quo_u : '0;
         row_ff       <= hit_in ? quo_v : '0;
         hit_ff       <= hit_in;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_x     = out_point_ff.x;
   assign rsp_chan.out_y     = out_point_ff.y;
   assign rsp_chan.out_z     = out_point_ff.z;
   assign rsp_chan.pixel_col = col_ff;
   assign rsp_chan.pixel_row = row_ff;
   assign rsp_chan.hit       = hit_ff;

endmodule
